[rtl/core/crt_pkg.sv]
// shared types and constants for the two-moduli crt solver
package crt_pkg;

    localparam int MOD_WIDTH = 32;
    localparam int PROD_WIDTH = 2 * MOD_WIDTH;

    typedef logic [MOD_WIDTH-1:0] word_t;
    typedef logic [PROD_WIDTH-1:0] dword_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_LOAD    = 4'd1,
        OP_RED_A   = 4'd2,
        OP_RED_B   = 4'd3,
        OP_GCD_INIT = 4'd4,
        OP_GCD_DIV = 4'd5,
        OP_GCD_S   = 4'd6,
        OP_DIFF    = 4'd7,
        OP_MUL_T   = 4'd8,
        OP_RED_T   = 4'd9,
        OP_MUL_N   = 4'd10,
        OP_FINISH  = 4'd11,
        OP_RED_AM  = 4'd12,
        OP_GCD_RED = 4'd13
    } op_t;

    typedef struct packed {
        op_t  op;
        logic unit_start;
        logic take;
    } dp_cmd_t;

    typedef struct packed {
        logic unit_busy;
        logic zero_mod;
        logic r1_zero;
        logic gcd_one;
    } dp_sts_t;

endpackage

[rtl/core/crt_two_moduli.sv]
// top level of the two-moduli chinese remainder solver
// One item at a time. The result takes longer the more euclid steps the moduli need
// (at most about 47 for 32-bit moduli), and only the load runs when a modulus is zero;
// the next item is taken in the cycle after the result. Every reduction, euclid
// division and multiplication runs bit-serially on one shared divide/multiply unit,
// sequenced through the issue, wait, take and done states; one euclid step is a
// divide, a multiply and a reduction.
module crt_two_moduli (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // residue_a[31:0], modulus_n[63:32], residue_b[95:64], modulus_m[127:96]
    input  logic [127:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // solution[63:0], combined_modulus[127:64], not_coprime[128]
    output logic [135:0]  m_tdata
);
    import crt_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    dword_t  sol, prod;
    logic    flag;

    crt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_tvalid && s_tready),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    crt_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .in_a             (s_tdata[31:0]),
        .in_n             (s_tdata[63:32]),
        .in_b             (s_tdata[95:64]),
        .in_m             (s_tdata[127:96]),
        .solution         (sol),
        .combined_modulus (prod),
        .not_coprime      (flag)
    );

    assign m_tdata = {7'd0, flag, prod, sol};

`ifndef SYNTHESIS
    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("ready while holding a result");
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && flag |-> sol == '0) else $error("flagged item with nonzero solution");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
`endif

endmodule

[rtl/core/crt_divmul.sv]
// shared unit: restoring divide of a 64-bit dividend, or shift-add multiply
module crt_divmul (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             mul_mode,
    input  crt_pkg::dword_t  op_a,
    input  crt_pkg::word_t   op_b,
    output logic             busy,
    output crt_pkg::dword_t  quo,
    output crt_pkg::word_t   rem
);
    import crt_pkg::*;

    localparam int CNT_W = $clog2(PROD_WIDTH + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             mode_reg;
    dword_t           acc_reg;
    logic [MOD_WIDTH:0] rem_reg;
    word_t            div_reg;
    dword_t           prod_reg;
    logic [MOD_WIDTH:0] trial;
    logic [MOD_WIDTH:0] shifted;

    assign shifted = {rem_reg[MOD_WIDTH-1:0], acc_reg[PROD_WIDTH-1]};
    assign trial = shifted - {1'b0, div_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = CNT_W'(mul_mode ? MOD_WIDTH : PROD_WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= mul_mode;
            acc_reg <= op_a;
            div_reg <= op_b;
            rem_reg <= '0;
            prod_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (mode_reg)
            begin
                // multiplier low word in acc, shift right one bit a step
                if (acc_reg[0])
                    prod_reg <= prod_reg + ({{MOD_WIDTH{1'b0}}, div_reg}
                        << (MOD_WIDTH - int'(cnt_reg)));
                acc_reg <= acc_reg >> 1;
            end
            else if (!trial[MOD_WIDTH] || shifted[MOD_WIDTH])
            begin
                rem_reg <= trial;
                acc_reg <= {acc_reg[PROD_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                acc_reg <= {acc_reg[PROD_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quo = mode_reg ? prod_reg : acc_reg;
    assign rem = rem_reg[MOD_WIDTH-1:0];

endmodule

[rtl/core/crt_datapath.sv]
// datapath: operand registers, euclid state and the shared divide/multiply unit
module crt_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  crt_pkg::dp_cmd_t  cmd,
    output crt_pkg::dp_sts_t  sts,
    input  crt_pkg::word_t    in_a,
    input  crt_pkg::word_t    in_n,
    input  crt_pkg::word_t    in_b,
    input  crt_pkg::word_t    in_m,
    output crt_pkg::dword_t   solution,
    output crt_pkg::dword_t   combined_modulus,
    output logic              not_coprime
);
    import crt_pkg::*;

    word_t  a_reg, n_reg, b_reg, m_reg;
    word_t  r0_reg, r1_reg, s0_reg, s1_reg, q_reg, t_reg;
    dword_t prod_reg, sol_reg;
    logic   flag_reg;
    logic   mul_mode;
    dword_t op_a;
    word_t  op_b;
    logic   busy;
    dword_t quo;
    word_t  rem;
    word_t  s_diff;
    word_t  s_step;

    always_comb
    begin
        mul_mode = 1'b0;
        op_a = '0;
        op_b = m_reg;
        unique case (cmd.op)
            OP_RED_A:  begin op_a = dword_t'(a_reg); op_b = n_reg; end
            OP_RED_B:  begin op_a = dword_t'(b_reg); end
            OP_RED_AM: begin op_a = dword_t'(a_reg); end
            OP_GCD_INIT: begin op_a = dword_t'(n_reg); end
            OP_GCD_DIV: begin op_a = dword_t'(r0_reg); op_b = r1_reg; end
            OP_GCD_S:  begin mul_mode = 1'b1; op_a = dword_t'(q_reg); op_b = s1_reg; end
            // the product left in the unit is reduced modulo m
            OP_GCD_RED: begin op_a = quo; end
            OP_MUL_T:  begin mul_mode = 1'b1; op_a = dword_t'(t_reg); op_b = s0_reg; end
            OP_RED_T:  begin op_a = quo; end
            OP_MUL_N:  begin mul_mode = 1'b1; op_a = dword_t'(t_reg); op_b = n_reg; end
            OP_LOAD:   begin mul_mode = 1'b1; op_a = dword_t'(in_n); op_b = in_m; end
            default:   begin op_a = '0; end
        endcase
    end

    crt_divmul u_divmul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.unit_start),
        .mul_mode (mul_mode),
        .op_a     (op_a),
        .op_b     (op_b),
        .busy     (busy),
        .quo      (quo),
        .rem      (rem)
    );

    // (b' + m - a'') mod m, with both below m
    assign s_diff = (b_reg >= t_reg) ? (b_reg - t_reg) : (b_reg + (m_reg - t_reg));
    // (s0 + m - q*s1 mod m) mod m
    assign s_step = (s0_reg >= rem) ? (s0_reg - rem) : (s0_reg + (m_reg - rem));

    // operands are captured as the item is accepted, results on the take strobe
    always_ff @(posedge clk)
    begin
        if (cmd.unit_start && cmd.op == OP_LOAD)
        begin
            a_reg <= in_a; n_reg <= in_n; b_reg <= in_b; m_reg <= in_m;
            flag_reg <= (in_n == '0) || (in_m == '0);
            sol_reg <= '0;
        end
        else if (cmd.take)
        begin
            unique case (cmd.op)
                OP_LOAD: prod_reg <= quo;
                OP_RED_A: a_reg <= rem;
                OP_RED_B: b_reg <= rem;
                OP_RED_AM: t_reg <= rem;
                OP_GCD_INIT:
                begin
                    r0_reg <= rem; r1_reg <= m_reg;
                    s0_reg <= (m_reg == word_t'(1)) ? '0 : word_t'(1);
                    s1_reg <= '0;
                end
                OP_GCD_DIV:
                begin
                    q_reg <= quo[MOD_WIDTH-1:0];
                    r0_reg <= r1_reg; r1_reg <= rem;
                end
                OP_GCD_RED:
                begin
                    s0_reg <= s1_reg;
                    s1_reg <= s_step;
                end
                OP_DIFF:
                begin
                    flag_reg <= (r0_reg != word_t'(1));
                    t_reg <= s_diff;
                end
                OP_RED_T: t_reg <= rem;
                OP_MUL_N: sol_reg <= quo + dword_t'(a_reg);
                OP_FINISH: if (flag_reg) sol_reg <= '0;
                default: ;
            endcase
        end
    end

    assign sts.unit_busy = busy;
    assign sts.zero_mod = flag_reg;
    assign sts.r1_zero = (r1_reg == '0);
    assign sts.gcd_one = (r0_reg == word_t'(1));
    assign solution = sol_reg;
    assign combined_modulus = prod_reg;
    assign not_coprime = flag_reg;

endmodule

[rtl/core/crt_ctrl.sv]
// controller: sequences reduction, extended euclid and the final products
module crt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output crt_pkg::dp_cmd_t  cmd,
    input  crt_pkg::dp_sts_t  sts
);
    import crt_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ISSUE = 6'b000010,
        ST_WAIT  = 6'b000100,
        ST_TAKE  = 6'b001000,
        ST_DONE  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   take_cycle;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign take_cycle = (state_reg == ST_TAKE);

    function automatic logic uses_unit(op_t o);
        return !(o == OP_DIFF || o == OP_FINISH);
    endfunction

    // next operation after op completes
    function automatic op_t after(op_t o, dp_sts_t s);
        op_t r;
        r = OP_FINISH;
        unique case (o)
            OP_LOAD:     r = s.zero_mod ? OP_FINISH : OP_RED_A;
            OP_RED_A:    r = OP_RED_B;
            OP_RED_B:    r = OP_GCD_INIT;
            OP_GCD_INIT: r = s.r1_zero ? OP_RED_AM : OP_GCD_DIV;
            OP_GCD_DIV:  r = OP_GCD_S;
            OP_GCD_S:    r = OP_GCD_RED;
            OP_GCD_RED:  r = s.r1_zero ? OP_RED_AM : OP_GCD_DIV;
            OP_RED_AM:   r = OP_DIFF;
            OP_DIFF:     r = OP_MUL_T;
            OP_MUL_T:    r = OP_RED_T;
            OP_RED_T:    r = OP_MUL_N;
            default:     r = OP_FINISH;
        endcase
        return r;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        unique case (state_reg)
            // the load multiply starts on the accepting edge
            ST_IDLE: if (in_fire) begin op_next = OP_LOAD; state_next = ST_WAIT; end
            ST_ISSUE: state_next = uses_unit(op_reg) ? ST_WAIT : ST_TAKE;
            ST_WAIT: if (!sts.unit_busy) state_next = ST_TAKE;
            ST_TAKE:
            begin
                if (op_reg == OP_FINISH) state_next = ST_OUT;
                else state_next = ST_DONE;
            end
            ST_DONE:
            begin
                op_next = after(op_reg, sts);
                state_next = ST_ISSUE;
            end
            ST_OUT: if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
        end
    end

    assign cmd.op = (state_reg == ST_IDLE) ? (in_fire ? OP_LOAD : OP_NONE)
        : ((take_cycle || state_reg == ST_ISSUE || state_reg == ST_WAIT) ? op_reg : OP_NONE);
    assign cmd.unit_start = ((state_reg == ST_ISSUE) && uses_unit(op_reg))
        || ((state_reg == ST_IDLE) && in_fire);
    assign cmd.take = take_cycle;

endmodule
